// ===== design/cau_pkg.sv =====
// Shared types, codes and constant tables of the complex arithmetic unit.
package cau_pkg;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_DIV   = 3'd3,
		CMD_MAG   = 3'd4,
		CMD_PHASE = 3'd5,
		CMD_EQ    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	localparam int N_STEPS      = 32;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} opnd_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               equal_flag;
		logic [1:0]         status;
	} res_t;

	// Working state of one item as it moves down the iteration stages.
	typedef struct packed {
		logic [2:0]         cmd;
		logic [1:0]         st;
		logic               eq;
		logic               neg_re;
		logic               neg_im;
		logic               ovf_re;
		logic               ovf_im;
		logic [31:0]        q_re;
		logic [31:0]        q_im;
		logic [31:0]        lo_re;
		logic [31:0]        lo_im;
		logic [64:0]        acc_re;
		logic [64:0]        acc_im;
		logic [63:0]        den;
		logic signed [45:0] cx;
		logic signed [45:0] cy;
		logic signed [33:0] cz;
	} lane_t;

	// Saturate a sign and magnitude value to 32 bits; the top bit flags saturation.
	function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
		logic [32:0] r;
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag[31:0]};
		end else begin
			if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, ~mag[31:0] + 32'd1};
		end
		return r;
	endfunction

	// Arctangent of 2^-i in Q2.30.
	function automatic logic signed [33:0] atan_q30(input int idx);
		logic signed [33:0] r;
		case (idx)
			0: r = 34'sd843314856;
			1: r = 34'sd497837829;
			2: r = 34'sd263043836;
			3: r = 34'sd133525158;
			4: r = 34'sd67021686;
			5: r = 34'sd33543515;
			6: r = 34'sd16775850;
			7: r = 34'sd8388437;
			8: r = 34'sd4194282;
			9: r = 34'sd2097149;
			10: r = 34'sd1048575;
			11: r = 34'sd524287;
			12: r = 34'sd262143;
			13: r = 34'sd131071;
			14: r = 34'sd65535;
			15: r = 34'sd32767;
			16: r = 34'sd16383;
			17: r = 34'sd8191;
			18: r = 34'sd4095;
			19: r = 34'sd2047;
			20: r = 34'sd1023;
			21: r = 34'sd511;
			22: r = 34'sd255;
			23: r = 34'sd127;
			24: r = 34'sd63;
			25: r = 34'sd31;
			26: r = 34'sd15;
			27: r = 34'sd7;
			28: r = 34'sd3;
			29: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/cau_front.sv =====
// Front stages: products, sums, saturation and setup of the iterative lanes.
module cau_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  cau_pkg::opnd_t opnd,
	output logic           out_valid,
	output cau_pkg::lane_t lane
);

	typedef struct packed {
		logic [2:0]         cmd;
		logic               eq;
		logic               bzero;
		logic               vzero;
		logic signed [32:0] sum_re;
		logic signed [32:0] sum_im;
		logic signed [63:0] p_rr;
		logic signed [63:0] p_ii;
		logic signed [63:0] p_ri;
		logic signed [63:0] p_ir;
		logic signed [63:0] p_br;
		logic signed [63:0] p_bi;
		logic signed [32:0] x0;
		logic signed [32:0] y0;
		logic signed [33:0] base;
		logic [5:0]         shift;
	} st1_t;

	st1_t d1, st_s1;
	cau_pkg::lane_t d2, lane_s2, d3, lane_s3;
	logic v_s1, v_s2, v_s3;

	logic signed [31:0] yr, yi;
	logic [31:0] abs_re, abs_im, mor;
	logic [4:0] msb;

	// Stage 1: the multipliers, the add and subtract sums, CORDIC quadrant fold.
	always_comb begin
		d1 = '0;
		d1.cmd = opnd.command;
		yr = (opnd.command == cau_pkg::CMD_MAG) ? opnd.a_re : opnd.b_re;
		yi = (opnd.command == cau_pkg::CMD_MAG) ? opnd.a_im : opnd.b_im;
		d1.p_rr = 64'(opnd.a_re) * 64'(yr);
		d1.p_ii = 64'(opnd.a_im) * 64'(yi);
		d1.p_ri = 64'(opnd.a_re) * 64'(opnd.b_im);
		d1.p_ir = 64'(opnd.a_im) * 64'(opnd.b_re);
		d1.p_br = 64'(opnd.b_re) * 64'(opnd.b_re);
		d1.p_bi = 64'(opnd.b_im) * 64'(opnd.b_im);
		if (opnd.command == cau_pkg::CMD_SUB) begin
			d1.sum_re = 33'(opnd.a_re) - 33'(opnd.b_re);
			d1.sum_im = 33'(opnd.a_im) - 33'(opnd.b_im);
		end else begin
			d1.sum_re = 33'(opnd.a_re) + 33'(opnd.b_re);
			d1.sum_im = 33'(opnd.a_im) + 33'(opnd.b_im);
		end
		d1.eq = (opnd.command == cau_pkg::CMD_EQ) && (opnd.a_re == opnd.b_re) &&
			(opnd.a_im == opnd.b_im);
		d1.bzero = (opnd.b_re == 32'sd0) && (opnd.b_im == 32'sd0);
		// A vector in the left half plane is turned by pi first.
		if (opnd.a_re < 32'sd0) begin
			d1.x0 = -33'(opnd.a_re);
			d1.y0 = -33'(opnd.a_im);
			d1.base = (opnd.a_im >= 32'sd0) ? cau_pkg::PI_Q30 : -cau_pkg::PI_Q30;
		end else begin
			d1.x0 = 33'(opnd.a_re);
			d1.y0 = 33'(opnd.a_im);
			d1.base = 34'sd0;
		end
		abs_re = opnd.a_re[31] ? (~opnd.a_re + 32'd1) : opnd.a_re;
		abs_im = opnd.a_im[31] ? (~opnd.a_im + 32'd1) : opnd.a_im;
		mor = abs_re | abs_im;
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (mor[i]) msb = 5'(i);
		end
		d1.vzero = (mor == 32'd0);
		// Scale so that the larger component lands at bit 40.
		d1.shift = 6'd40 - {1'b0, msb};
	end

	// Stage 2: add and subtract saturation, the wide sums and denominator, and the CORDIC normalizing shift.
	always_comb begin
		d2 = '0;
		d2.cmd = st_s1.cmd;
		d2.st = cau_pkg::ST_OK;
		case (cau_pkg::cmd_t'(st_s1.cmd))
			cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
				d2.ovf_re = st_s1.sum_re[32] != st_s1.sum_re[31];
				d2.ovf_im = st_s1.sum_im[32] != st_s1.sum_im[31];
				d2.q_re = d2.ovf_re ? (st_s1.sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
					: st_s1.sum_re[31:0];
				d2.q_im = d2.ovf_im ? (st_s1.sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
					: st_s1.sum_im[31:0];
			end
			cau_pkg::CMD_MUL: begin
				d2.acc_re = 65'(st_s1.p_rr) - 65'(st_s1.p_ii);
				d2.acc_im = 65'(st_s1.p_ri) + 65'(st_s1.p_ir);
			end
			cau_pkg::CMD_DIV: begin
				d2.acc_re = 65'(st_s1.p_rr) + 65'(st_s1.p_ii);
				d2.acc_im = 65'(st_s1.p_ir) - 65'(st_s1.p_ri);
				d2.den = $unsigned(st_s1.p_br) + $unsigned(st_s1.p_bi);
				d2.st = st_s1.bzero ? cau_pkg::ST_ZERO : cau_pkg::ST_OK;
			end
			cau_pkg::CMD_MAG: begin
				d2.acc_re = 65'(st_s1.p_rr) + 65'(st_s1.p_ii);
			end
			cau_pkg::CMD_PHASE: begin
				d2.cx = 46'(st_s1.x0) << st_s1.shift;
				d2.cy = 46'(st_s1.y0) << st_s1.shift;
				d2.cz = st_s1.base;
				d2.st = st_s1.vzero ? cau_pkg::ST_ZERO : cau_pkg::ST_OK;
			end
			cau_pkg::CMD_EQ: begin
				d2.eq = st_s1.eq;
			end
			default: begin
			end
		endcase
	end

	logic [64:0] neg_re, neg_im;
	logic [63:0] mag_re, mag_im;
	logic [32:0] sat_re, sat_im;

	// Stage 3: magnitudes, product truncation and divider setup.
	always_comb begin
		d3 = lane_s2;
		neg_re = -lane_s2.acc_re;
		neg_im = -lane_s2.acc_im;
		mag_re = lane_s2.acc_re[64] ? neg_re[63:0] : lane_s2.acc_re[63:0];
		mag_im = lane_s2.acc_im[64] ? neg_im[63:0] : lane_s2.acc_im[63:0];
		sat_re = cau_pkg::sat_mag(lane_s2.acc_re[64], mag_re >> FRAC_BITS);
		sat_im = cau_pkg::sat_mag(lane_s2.acc_im[64], mag_im >> FRAC_BITS);
		case (cau_pkg::cmd_t'(lane_s2.cmd))
			cau_pkg::CMD_MUL: begin
				d3.q_re = sat_re[31:0];
				d3.q_im = sat_im[31:0];
				d3.ovf_re = sat_re[32];
				d3.ovf_im = sat_im[32];
			end
			cau_pkg::CMD_DIV: begin
				// The scaled numerator splits into a starting remainder and 32 low bits.
				d3.neg_re = lane_s2.acc_re[64];
				d3.neg_im = lane_s2.acc_im[64];
				d3.acc_re = {1'b0, mag_re >> (32 - FRAC_BITS)};
				d3.acc_im = {1'b0, mag_im >> (32 - FRAC_BITS)};
				d3.ovf_re = (mag_re >> (32 - FRAC_BITS)) >= lane_s2.den;
				d3.ovf_im = (mag_im >> (32 - FRAC_BITS)) >= lane_s2.den;
				d3.lo_re = 32'(mag_re << FRAC_BITS);
				d3.lo_im = 32'(mag_im << FRAC_BITS);
				d3.q_re = '0;
				d3.q_im = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= d1;
			lane_s2 <= d2;
			lane_s3 <= d3;
		end
	end

	assign out_valid = v_s3;
	assign lane = lane_s3;

endmodule

// ===== design/cau_step.sv =====
// One iteration stage: a divider step per part, a square root step, a CORDIC step.
module cau_step #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  cau_pkg::lane_t in_lane,
	output logic           out_valid,
	output cau_pkg::lane_t out_lane
);

	cau_pkg::lane_t nxt, lane_sn;
	logic valid_sn;
	logic [64:0] r2_re, r2_im, bit_v, trial;
	logic ge_re, ge_im;
	logic signed [45:0] dx, dy;
	logic signed [33:0] ang;

	always_comb begin
		nxt = in_lane;
		r2_re = {in_lane.acc_re[63:0], in_lane.lo_re[31]};
		r2_im = {in_lane.acc_im[63:0], in_lane.lo_im[31]};
		ge_re = r2_re >= {1'b0, in_lane.den};
		ge_im = r2_im >= {1'b0, in_lane.den};
		bit_v = 65'd1 << (62 - 2 * STEP);
		trial = in_lane.acc_im + bit_v;
		dx = in_lane.cy >>> STEP;
		dy = in_lane.cx >>> STEP;
		ang = cau_pkg::atan_q30(STEP);
		case (cau_pkg::cmd_t'(in_lane.cmd))
			cau_pkg::CMD_DIV: begin
				nxt.acc_re = ge_re ? r2_re - {1'b0, in_lane.den} : r2_re;
				nxt.acc_im = ge_im ? r2_im - {1'b0, in_lane.den} : r2_im;
				nxt.q_re = {in_lane.q_re[30:0], ge_re};
				nxt.q_im = {in_lane.q_im[30:0], ge_im};
				nxt.lo_re = in_lane.lo_re << 1;
				nxt.lo_im = in_lane.lo_im << 1;
			end
			cau_pkg::CMD_MAG: begin
				// Remainder in acc_re, root under construction in acc_im.
				if (in_lane.acc_re >= trial) begin
					nxt.acc_re = in_lane.acc_re - trial;
					nxt.acc_im = (in_lane.acc_im >> 1) + bit_v;
				end else begin
					nxt.acc_im = in_lane.acc_im >> 1;
				end
			end
			cau_pkg::CMD_PHASE: begin
				if (STEP < cau_pkg::CORDIC_STEPS) begin
					if (in_lane.cy < 46'sd0) begin
						nxt.cx = in_lane.cx - dx;
						nxt.cy = in_lane.cy + dy;
						nxt.cz = in_lane.cz - ang;
					end else begin
						nxt.cx = in_lane.cx + dx;
						nxt.cy = in_lane.cy - dy;
						nxt.cz = in_lane.cz + ang;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_sn <= 1'b0;
		else if (adv) valid_sn <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) lane_sn <= nxt;
	end

	assign out_valid = valid_sn;
	assign out_lane = lane_sn;

endmodule

// ===== design/cau_post.sv =====
// Final stage: quotient and root saturation, phase rounding, output register.
module cau_post #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  cau_pkg::lane_t in_lane,
	output logic           out_valid,
	output cau_pkg::res_t  out_res
);

	cau_pkg::res_t r, res_s;
	logic valid_s;
	logic ov;
	logic [32:0] sr, si;
	logic signed [33:0] zr, zs;

	always_comb begin
		r = '0;
		ov = 1'b0;
		sr = cau_pkg::sat_mag(in_lane.neg_re, {32'd0, in_lane.q_re});
		si = cau_pkg::sat_mag(in_lane.neg_im, {32'd0, in_lane.q_im});
		zr = in_lane.cz + (34'sd1 <<< (29 - FRAC_BITS));
		zs = zr >>> (30 - FRAC_BITS);
		r.status = in_lane.st;
		case (cau_pkg::cmd_t'(in_lane.cmd))
			cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL: begin
				r.res_re = in_lane.q_re;
				r.res_im = in_lane.q_im;
				ov = in_lane.ovf_re | in_lane.ovf_im;
			end
			cau_pkg::CMD_DIV: begin
				if (in_lane.st == cau_pkg::ST_OK) begin
					// A quotient that is 2^32 or more saturates whatever its low bits.
					if (in_lane.ovf_re) r.res_re = in_lane.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
					else r.res_re = sr[31:0];
					if (in_lane.ovf_im) r.res_im = in_lane.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
					else r.res_im = si[31:0];
					ov = in_lane.ovf_re | in_lane.ovf_im | sr[32] | si[32];
				end
			end
			cau_pkg::CMD_MAG: begin
				sr = cau_pkg::sat_mag(1'b0, in_lane.acc_im[63:0]);
				r.res_re = sr[31:0];
				ov = sr[32];
			end
			cau_pkg::CMD_PHASE: begin
				if (in_lane.st == cau_pkg::ST_OK) r.res_re = zs[31:0];
			end
			cau_pkg::CMD_EQ: begin
				r.equal_flag = in_lane.eq;
			end
			default: begin
				r.status = cau_pkg::ST_OK;
			end
		endcase
		if (ov) r.status = cau_pkg::ST_SAT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s <= 1'b0;
		else if (adv) valid_s <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) res_s <= r;
	end

	assign out_valid = valid_s;
	assign out_res = res_s;

endmodule

// ===== design/complex_arith_unit_top.sv =====
// Top level of the pipelined complex arithmetic unit.
//
// Operands arrive on the opnd channel (opnd_valid, opnd_ready, opnd): a command
// and two complex Q16.16 operands. Results leave on the res channel (res_valid,
// res_ready, res), one result for every operand transfer, in order.
// The unit is a fixed pipeline of 36 register stages: three front stages hold
// the multipliers, the wide sums and the divider setup, 32 iteration stages
// each carry one restoring divide step for both parts, one square root step
// and (in the first 30) one CORDIC vectoring step, and a last stage saturates,
// rounds and drives the output register. One operand transfer is taken in every
// cycle in which the pipeline is not held by a waiting result.
// Valid bits travel with the data; all stages advance together whenever the
// output register is empty or its result is being taken in the same cycle.
// When the receiver holds res_ready low with a result waiting, the whole
// pipeline holds its contents and opnd_ready drops, so nothing is lost or
// repeated. Reset clears every valid bit; the pipeline is ready at once.
module complex_arith_unit_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           opnd_valid,
	output logic           opnd_ready,
	input  cau_pkg::opnd_t opnd,
	output logic           res_valid,
	input  logic           res_ready,
	output cau_pkg::res_t  res
);

	// Global advance: the output register can take a new result.
	logic adv;
	logic           chain_valid [0:cau_pkg::N_STEPS];
	cau_pkg::lane_t chain_lane  [0:cau_pkg::N_STEPS];

	assign adv = !res_valid || res_ready;
	assign opnd_ready = adv;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(opnd_valid),
		.opnd(opnd),
		.out_valid(chain_valid[0]),
		.lane(chain_lane[0])
	);

	// Iteration stages of the divider, square root and CORDIC lanes.
	for (genvar g = 0; g < cau_pkg::N_STEPS; g++) begin : g_step
		cau_step #(.STEP(g)) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.in_valid(chain_valid[g]),
			.in_lane(chain_lane[g]),
			.out_valid(chain_valid[g + 1]),
			.out_lane(chain_lane[g + 1])
		);
	end

	cau_post #(.FRAC_BITS(FRAC_BITS)) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(chain_valid[cau_pkg::N_STEPS]),
		.in_lane(chain_lane[cau_pkg::N_STEPS]),
		.out_valid(res_valid),
		.out_res(res)
	);

endmodule
